/* design/udpb_pkg.sv */
// ----------------------------------------------------------------------------
// udpb_pkg: shared types and constants of the UDP/IPv4 frame builder
// Header geometry, register indexes, queue entry and configuration bundle.
// ----------------------------------------------------------------------------
package udpb_pkg;

	localparam int HDR_BYTES   = 42;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 48;

	localparam logic [15:0] MAX_PAYLOAD  = 16'd1472;
	localparam logic [15:0] IP_UDP_BYTES = 16'd28;
	localparam logic [15:0] UDP_BYTES    = 16'd8;

	// fixed IPv4 header words: 0x4500 + ID 0x0001 + flags 0x4000 + TTL/proto 0x4011
	localparam logic [18:0] CK_CONST = 19'h0C512;
	// header word at which the checksum is latched, well before it goes out
	localparam logic [5:0]  CK_LOAD_IDX = 6'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_MAC  = 3'd0,
		REG_DEST_MAC    = 3'd1,
		REG_SOURCE_IP   = 3'd2,
		REG_DEST_IP     = 3'd3,
		REG_SOURCE_PORT = 3'd4,
		REG_DEST_PORT   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [47:0] source_mac;
		logic [47:0] dest_mac;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} cfg_regs_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] length;
		logic        start;
		logic        last;
	} q_entry_t;

endpackage

/* design/udpb_if.sv */
// ----------------------------------------------------------------------------
// udpb_if: channel interfaces of the UDP/IPv4 frame builder
// Payload input, frame output and configuration write channels.
// ----------------------------------------------------------------------------
interface udpb_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic [15:0] payload_length;
	modport source (output valid, payload_byte, payload_length, input ready);
	modport sink   (input valid, payload_byte, payload_length, output ready);
endinterface

interface udpb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;
	modport source (output valid, frame_byte, last_byte, input ready);
	modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface udpb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [47:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* design/udpb_front.sv */
// ----------------------------------------------------------------------------
// udpb_front: input side of the frame builder
// Tracks frame position, drops empty and oversize frames, queues kept words.
// ----------------------------------------------------------------------------
module udpb_front (
	input  logic              clk,
	input  logic              arst_n,
	udpb_in_if.sink           payload,
	input  logic              q_full,
	output logic              q_push,
	output udpb_pkg::q_entry_t q_entry
);
	import udpb_pkg::*;

	logic [15:0] pos_q;
	logic [15:0] flen_q;
	logic        drop_q;

	logic        accept;
	logic        first;
	logic        skip;
	logic        drop_now;
	logic        last;
	logic [15:0] len_now;

	assign payload.ready = !q_full;
	assign accept = payload.valid && payload.ready;

	always_comb begin
		first    = (pos_q == 16'd0);
		len_now  = first ? payload.payload_length : flen_q;
		skip     = first && (payload.payload_length == 16'd0);
		drop_now = first ? (payload.payload_length > MAX_PAYLOAD) : drop_q;
		last     = (({1'b0, pos_q} + 17'd1) == {1'b0, len_now});
	end

	assign q_push        = accept && !skip && !drop_now;
	assign q_entry.data   = payload.payload_byte;
	assign q_entry.length = len_now;
	assign q_entry.start  = first;
	assign q_entry.last   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			flen_q <= '0;
			drop_q <= 1'b0;
		end else if (accept && !skip) begin
			flen_q <= len_now;
			if (last) begin
				pos_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				pos_q  <= pos_q + 16'd1;
				drop_q <= drop_now;
			end
		end
	end

endmodule

/* design/udpb_fifo.sv */
// ----------------------------------------------------------------------------
// udpb_fifo: short word queue between front and back
// Register-based circular buffer, head word visible while not empty.
// ----------------------------------------------------------------------------
module udpb_fifo #(
	parameter int DEPTH = udpb_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  udpb_pkg::q_entry_t push_entry,
	input  logic               pop,
	output udpb_pkg::q_entry_t head,
	output logic               full,
	output logic               empty
);
	import udpb_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_entry_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* design/udpb_back.sv */
// ----------------------------------------------------------------------------
// udpb_back: output side of the frame builder
// Inserts the 42-byte header ahead of a frame's first word, then passes data.
// ----------------------------------------------------------------------------
module udpb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  udpb_pkg::cfg_regs_t regs,
	input  udpb_pkg::q_entry_t  head,
	input  logic                q_empty,
	output logic                q_pop,
	udpb_out_if.source          frame
);
	import udpb_pkg::*;

	logic [18:0]  raw_q;
	logic [15:0]  base_q;
	logic [15:0]  ck_q;
	logic [5:0]   cnt_q;
	logic         out_valid_q;
	logic [7:0]   byte_q;
	logic         last_q;

	logic [16:0]  fold_raw;
	logic [15:0]  total;
	logic [15:0]  ulen;
	logic [16:0]  ck_sum;
	logic [15:0]  ck_fold;
	logic [HDR_BYTES*8-1:0] hdr_vec;
	logic [5:0]   hdr_idx;
	logic [7:0]   hdr_byte;
	logic         load;
	logic         in_hdr;

	// config-only part of the IPv4 checksum, folded to 16 bits over two stages
	always_ff @(posedge clk) begin
		raw_q  <= CK_CONST
		        + {3'b0, regs.source_ip[31:16]} + {3'b0, regs.source_ip[15:0]}
		        + {3'b0, regs.dest_ip[31:16]}   + {3'b0, regs.dest_ip[15:0]};
		base_q <= fold_raw[15:0] + {15'b0, fold_raw[16]};
	end

	always_comb begin
		fold_raw = {1'b0, raw_q[15:0]} + {14'b0, raw_q[18:16]};
		total    = head.length + IP_UDP_BYTES;
		ulen     = head.length + UDP_BYTES;
		ck_sum   = {1'b0, base_q} + {1'b0, total};
		ck_fold  = ck_sum[15:0] + {15'b0, ck_sum[16]};
		hdr_vec  = {regs.dest_mac, regs.source_mac, 16'h0800,
		            8'h45, 8'h00, total, 16'h0001, 16'h4000, 8'd64, 8'd17,
		            ck_q, regs.source_ip, regs.dest_ip,
		            regs.source_port, regs.dest_port, ulen, 16'h0000};
		hdr_idx  = 6'(HDR_BYTES - 1) - cnt_q;
		hdr_byte = hdr_vec[{hdr_idx, 3'b000} +: 8];
	end

	assign load   = !out_valid_q || frame.ready;
	assign in_hdr = head.start && (cnt_q != 6'(HDR_BYTES));
	assign q_pop  = load && !q_empty && !in_hdr;

	always_ff @(posedge clk) begin
		if (load && !q_empty && in_hdr && (cnt_q == CK_LOAD_IDX)) begin
			ck_q <= ~ck_fold;
		end
		if (load && !q_empty) begin
			if (in_hdr) begin
				byte_q <= hdr_byte;
				last_q <= 1'b0;
			end else begin
				byte_q <= head.data;
				last_q <= head.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				cnt_q <= in_hdr ? cnt_q + 6'd1 : 6'd0;
			end
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = byte_q;
	assign frame.last_byte  = last_q;

endmodule

/* design/udp_ipv4_frame_builder.sv */
// ----------------------------------------------------------------------------
// udp_ipv4_frame_builder: Ethernet/IPv4/UDP encapsulation of a byte stream
// Writes the 42-byte wire header in front of each payload frame.
// ----------------------------------------------------------------------------
// Usage:
//   cfg     - register writes (MACs, IPs, ports); always ready. Write only
//             while no frame is in flight.
//   payload - one payload word per accept, each carrying the frame length;
//             the length is sampled on the first word of a frame. Frames of
//             length zero or above 1472 are swallowed without output.
//   frame   - wire words in order, last_byte set on the final one.
// Path: a frame's first payload word is written into the queue; while it
//   waits at the head, the back end registers the header words out ahead
//   of it; payload words pass from the queue through the output register.
// Throughput: one output word per cycle unless stalled or the queue is empty.
//   A frame of N payload words gives N + 42 output words; the header is
//   generated by the back end while the front keeps filling the 4-deep queue.
// Stall: when frame.ready is low the output word holds; the queue fills and
//   payload.ready drops once it is full.
// Reset: zeroes config and control state, empties queue, starts a new frame.
// ----------------------------------------------------------------------------
module udp_ipv4_frame_builder #(
	parameter int QUEUE_DEPTH = udpb_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	udpb_cfg_if.sink   cfg,
	udpb_in_if.sink    payload,
	udpb_out_if.source frame
);
	import udpb_pkg::*;

	cfg_regs_t regs_q;
	q_entry_t  push_entry;
	q_entry_t  head;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SOURCE_MAC:  regs_q.source_mac  <= cfg.data;
				REG_DEST_MAC:    regs_q.dest_mac    <= cfg.data;
				REG_SOURCE_IP:   regs_q.source_ip   <= cfg.data[31:0];
				REG_DEST_IP:     regs_q.dest_ip     <= cfg.data[31:0];
				REG_SOURCE_PORT: regs_q.source_port <= cfg.data[15:0];
				REG_DEST_PORT:   regs_q.dest_port   <= cfg.data[15:0];
				default:         regs_q <= regs_q;
			endcase
		end
	end

	udpb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (push_entry)
	);

	udpb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	udpb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.regs    (regs_q),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.frame   (frame)
	);

endmodule

/* design/udpb_checker.sv */
// ----------------------------------------------------------------------------
// udpb_checker: port-level checks of the frame builder
// Output hold, reset, config readiness and header length before last word.
// ----------------------------------------------------------------------------
module udpb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] frame_byte,
	input logic       last_byte
);
	import udpb_pkg::*;

	localparam int CW = $clog2(HDR_BYTES + 1);

	logic [CW-1:0] words_q;

	// words accepted in the current frame, saturating once the header is out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
		end else if (out_valid && out_ready) begin
			if (last_byte) begin
				words_q <= '0;
			end else if (words_q != CW'(HDR_BYTES)) begin
				words_q <= words_q + CW'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
		else $error("output word changed while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

	a_hdr_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |-> words_q == CW'(HDR_BYTES))
		else $error("frame ended before a full header");

endmodule

bind udp_ipv4_frame_builder udpb_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_valid  (cfg.valid),
	.cfg_ready  (cfg.ready),
	.out_valid  (frame.valid),
	.out_ready  (frame.ready),
	.frame_byte (frame.frame_byte),
	.last_byte  (frame.last_byte)
);
